// ===== sv/umbs_pkg.sv =====
`timescale 1ns / 1ps

package umbs_pkg;

   // SysEx store geometry
   localparam int SYSEX_DEPTH = 64;
   localparam int ADDR_W      = $clog2(SYSEX_DEPTH);
   localparam int FILL_W      = $clog2(SYSEX_DEPTH + 1);

   // Code index numbers (low nibble of the packet header)
   localparam logic [3:0] CIN_SYSEX_CONT  = 4'h4;
   localparam logic [3:0] CIN_SYSEX_END1  = 4'h5;
   localparam logic [3:0] CIN_SYSEX_END2  = 4'h6;
   localparam logic [3:0] CIN_SYSEX_END3  = 4'h7;
   localparam logic [3:0] CIN_NOTE_OFF    = 4'h8;
   localparam logic [3:0] CIN_NOTE_ON     = 4'h9;
   localparam logic [3:0] CIN_POLY_PRESS  = 4'hA;
   localparam logic [3:0] CIN_CTRL_CHANGE = 4'hB;
   localparam logic [3:0] CIN_PROG_CHANGE = 4'hC;
   localparam logic [3:0] CIN_CHAN_PRESS  = 4'hD;
   localparam logic [3:0] CIN_PITCH_BEND  = 4'hE;
   localparam logic [3:0] CIN_SINGLE_BYTE = 4'hF;

   localparam logic [3:0] CIN_MASK      = 4'hF;
   localparam logic [7:0] REALTIME_MASK = 8'hF8;

   // What a captured packet asks for
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_EMIT   = 2'd1;
   localparam logic [1:0] KIND_APPEND = 2'd2;
   localparam logic [1:0] KIND_FINISH = 2'd3;

   // Controller to datapath
   typedef struct packed {
      logic capture;     // latch packet, clear byte index
      logic emit;        // load packet byte into output register
      logic append;      // write packet byte to store if room
      logic play_start;  // clear playback address
      logic play_send;   // load store byte into output register
      logic fill_clear;  // empty the store
   } umbs_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic [1:0] kind;
      logic       idx_last;   // byte index at last byte of packet
      logic       fill_ge2;   // store holds a playable message
      logic       play_last;  // playback address at last stored byte
      logic       out_free;   // output register can take a byte
   } umbs_status_type;

endpackage

// ===== sv/umbs_ram.sv =====
`timescale 1ns / 1ps

module umbs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/umbs_datapath.sv =====
`timescale 1ns / 1ps

module umbs_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  umbs_pkg::umbs_cmd_type cmd,
   output umbs_pkg::umbs_status_type status,
   input  logic [7:0]             header,
   input  logic [7:0]             data_first,
   input  logic [7:0]             data_second,
   input  logic [7:0]             data_third,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [7:0]             out_byte,
   output logic                   out_last
);

   // Captured packet
   logic [3:0] cin_ff;
   logic [7:0] d0_ff, d1_ff, d2_ff;

   // Byte index within packet, store fill, playback address
   logic [1:0]                  idx_ff, idx_in;
   logic [umbs_pkg::FILL_W-1:0] fill_ff, fill_in;
   logic [umbs_pkg::ADDR_W-1:0] play_ff, play_in;

   // Output register
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;

   logic [1:0] kind;
   logic [1:0] count_m1;
   logic [7:0] cur_byte;
   logic [7:0] ram_rd_data;
   logic       store_room;
   logic       ram_wr_en;

   // Packet decode
   always_comb begin
      kind     = umbs_pkg::KIND_NONE;
      count_m1 = 2'd0;
      unique case (cin_ff)
         umbs_pkg::CIN_NOTE_OFF, umbs_pkg::CIN_NOTE_ON, umbs_pkg::CIN_POLY_PRESS,
         umbs_pkg::CIN_CTRL_CHANGE, umbs_pkg::CIN_PITCH_BEND: begin
            kind     = umbs_pkg::KIND_EMIT;
            count_m1 = 2'd2;
         end
         umbs_pkg::CIN_PROG_CHANGE, umbs_pkg::CIN_CHAN_PRESS: begin
            kind     = umbs_pkg::KIND_EMIT;
            count_m1 = 2'd1;
         end
         umbs_pkg::CIN_SINGLE_BYTE: begin
            // realtime bytes only
            if ((d0_ff & umbs_pkg::REALTIME_MASK) == umbs_pkg::REALTIME_MASK) begin
               kind = umbs_pkg::KIND_EMIT;
            end
         end
         umbs_pkg::CIN_SYSEX_CONT: begin
            kind     = umbs_pkg::KIND_APPEND;
            count_m1 = 2'd2;
         end
         umbs_pkg::CIN_SYSEX_END1: begin
            kind = umbs_pkg::KIND_FINISH;
         end
         umbs_pkg::CIN_SYSEX_END2: begin
            kind     = umbs_pkg::KIND_FINISH;
            count_m1 = 2'd1;
         end
         umbs_pkg::CIN_SYSEX_END3: begin
            kind     = umbs_pkg::KIND_FINISH;
            count_m1 = 2'd2;
         end
         default: begin
            kind = umbs_pkg::KIND_NONE;
         end
      endcase
   end

   // Current packet byte
   always_comb begin
      unique case (idx_ff)
         2'd0:    cur_byte = d0_ff;
         2'd1:    cur_byte = d1_ff;
         default: cur_byte = d2_ff;
      endcase
   end

   assign store_room = (fill_ff < umbs_pkg::FILL_W'(umbs_pkg::SYSEX_DEPTH));
   assign ram_wr_en  = cmd.append && store_room;

   // Counters
   always_comb begin
      idx_in  = idx_ff;
      fill_in = fill_ff;
      play_in = play_ff;
      if (cmd.capture) begin
         idx_in = 2'd0;
      end else if (cmd.emit || cmd.append) begin
         idx_in = idx_ff + 2'd1;
      end
      if (cmd.fill_clear) begin
         fill_in = '0;
      end else if (ram_wr_en) begin
         fill_in = fill_ff + umbs_pkg::FILL_W'(1);
      end
      if (cmd.play_start) begin
         play_in = '0;
      end else if (cmd.play_send) begin
         play_in = play_ff + umbs_pkg::ADDR_W'(1);
      end
   end

   // Output register
   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      last_in  = last_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
         byte_in  = cur_byte;
         last_in  = status.idx_last;
      end else if (cmd.play_send) begin
         valid_in = 1'b1;
         byte_in  = ram_rd_data;
         last_in  = status.play_last;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fill_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         fill_ff  <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cin_ff <= header[3:0] & umbs_pkg::CIN_MASK;
         d0_ff  <= data_first;
         d1_ff  <= data_second;
         d2_ff  <= data_third;
      end
      idx_ff  <= idx_in;
      play_ff <= play_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   // SysEx store
   umbs_ram #(
      .WIDTH (8),
      .DEPTH (umbs_pkg::SYSEX_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (fill_ff[umbs_pkg::ADDR_W-1:0]),
      .wr_data (cur_byte),
      .rd_addr (play_ff),
      .rd_data (ram_rd_data)
   );

   // Status
   assign status.kind      = kind;
   assign status.idx_last  = (idx_ff == count_m1);
   assign status.fill_ge2  = (fill_ff >= umbs_pkg::FILL_W'(2));
   assign status.play_last =
      ((umbs_pkg::FILL_W'(play_ff) + umbs_pkg::FILL_W'(1)) == fill_ff);
   assign status.out_free  = !valid_ff || out_ready;

   assign out_valid = valid_ff;
   assign out_byte  = byte_ff;
   assign out_last  = last_ff;

endmodule

// ===== sv/umbs_ctrl.sv =====
`timescale 1ns / 1ps

module umbs_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  umbs_pkg::umbs_status_type status,
   output umbs_pkg::umbs_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_DECODE  = 3'd1;
   localparam logic [2:0] ST_EMIT    = 3'd2;
   localparam logic [2:0] ST_APPEND  = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;
   localparam logic [2:0] ST_PLAY_RD = 3'd5;
   localparam logic [2:0] ST_PLAY_TX = 3'd6;

   logic [2:0] state_ff, state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      in_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready = 1'b1;
            if (in_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (status.kind)
               umbs_pkg::KIND_EMIT:   state_in = ST_EMIT;
               umbs_pkg::KIND_APPEND,
               umbs_pkg::KIND_FINISH: state_in = ST_APPEND;
               default:               state_in = ST_IDLE;
            endcase
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_APPEND: begin
            cmd.append = 1'b1;
            if (status.idx_last) begin
               state_in = (status.kind == umbs_pkg::KIND_FINISH) ? ST_FINISH : ST_IDLE;
            end
         end
         ST_FINISH: begin
            // two or more stored bytes: play them back; a short message: drop it
            if (status.fill_ge2) begin
               cmd.play_start = 1'b1;
               state_in       = ST_PLAY_RD;
            end else begin
               cmd.fill_clear = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_PLAY_RD: begin
            state_in = ST_PLAY_TX;
         end
         ST_PLAY_TX: begin
            if (status.out_free) begin
               cmd.play_send = 1'b1;
               if (status.play_last) begin
                  cmd.fill_clear = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  state_in = ST_PLAY_RD;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/usb_midi_packet_to_byte_stream_unit.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Handshake             | Payload
// req_    | in  | req_tvalid/req_tready | tdata: data_first, data_second, data_third;
//         |     |                       | tuser: header
// rsp_    | out | rsp_tvalid/rsp_tready | tdata: midi_byte; tlast: message_end
//
// One packet at a time: accept, a decode state, then the emit or append state
// for each emitted or stored byte.
// SysEx playback reads the store through its registered port, alternating a
// read state and a send state for each stored byte.
// Synchronous active-high reset empties the store and drops any pending byte.
// A stalled rsp_ side holds the sequencer; the next packet is taken while the
// final byte of the previous one waits in the output register.

module usb_midi_packet_to_byte_stream_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [7:0] data_first, [15:8] data_second, [23:16] data_third
   input  logic [7:0]  req_tuser,   // [7:0] header
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] midi_byte
   output logic        rsp_tlast
);

   umbs_pkg::umbs_cmd_type    cmd;
   umbs_pkg::umbs_status_type status;

   umbs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .status   (status),
      .cmd      (cmd)
   );

   umbs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .header      (req_tuser),
      .data_first  (req_tdata[7:0]),
      .data_second (req_tdata[15:8]),
      .data_third  (req_tdata[23:16]),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_byte    (rsp_tdata),
      .out_last    (rsp_tlast)
   );

endmodule
